// ----- rtl/sar_pkg.sv -----
package sar_pkg;

   localparam int TABLE_ENTRIES = 8;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic [15:0] ARP_HW_ETHERNET = 16'h0001;
   localparam logic [15:0] ARP_PROTO_IPV4 = 16'h0800;
   localparam logic [7:0] ARP_HW_LEN = 8'd6;
   localparam logic [7:0] ARP_PROTO_LEN = 8'd4;
   localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
   localparam logic [47:0] MCAST_PREFIX = 48'h01005e000000;
   localparam logic [3:0] MCAST_NIBBLE = 4'he;
   localparam logic [15:0] LINK_LOCAL_PREFIX = 16'ha9fe;
   localparam logic [6:0] MCAST_HIGH_BITS = 7'h7f;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOCAL_IP,
      CSR_SUBNET_MASK,
      CSR_GATEWAY_IP,
      CSR_LOCAL_MAC
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_ARP,
      KIND_RESOLVE,
      KIND_ADD,
      KIND_REMOVE
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_BAD_HDR,
      ST_IGNORED,
      ST_UNK_OP,
      ST_NO_ROUTE,
      ST_NOT_UNICAST,
      ST_FULL,
      ST_NOT_FOUND
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_SEND_IP,
      ACT_SEND_REPLY
   } action_type;

   typedef enum logic [1:0] {
      OP_DONE,
      OP_RESOLVE,
      OP_ADD,
      OP_REMOVE
   } op_type;

   typedef struct packed {
      kind_type kind;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [7:0] hw_len;
      logic [7:0] proto_len;
      logic [15:0] arp_opcode;
      logic [31:0] ip_addr;
      logic [47:0] mac_addr;
      logic [31:0] target_ip;
   } req_type;

   typedef struct packed {
      status_type status;
      action_type action;
      logic [47:0] dest_mac;
      logic [31:0] reply_ip;
   } rsp_type;

   typedef struct packed {
      op_type op;
      status_type status;
      action_type action;
      logic [31:0] ip;
      logic [47:0] mac;
   } cmd_type;

endpackage

// ----- rtl/sar_front.sv -----
module sar_front (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sar_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sar_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic push,
   input  sar_pkg::req_type req_data,
   input  logic cmd_full,
   output logic cmd_push,
   output sar_pkg::cmd_type cmd_data
);
   import sar_pkg::*;

   logic [31:0] local_ip_ff;
   logic [31:0] subnet_mask_ff;
   logic [31:0] gateway_ip_ff;
   logic bcast;
   logic mcast;
   logic off_subnet;
   logic bad_hdr;

   assign csr_ready = 1'b1;
   assign cmd_push = push && !cmd_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff <= '0;
         subnet_mask_ff <= '0;
         gateway_ip_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LOCAL_IP: local_ip_ff <= csr_data[31:0];
            CSR_SUBNET_MASK: subnet_mask_ff <= csr_data[31:0];
            CSR_GATEWAY_IP: gateway_ip_ff <= csr_data[31:0];
            // source mac of replies is built outside this block
            CSR_LOCAL_MAC: ;
            default: ;
         endcase
      end
   end

   assign bcast = (req_data.ip_addr == '1) || (req_data.ip_addr == '0) ||
                  (((req_data.ip_addr & ~subnet_mask_ff) == ~subnet_mask_ff) &&
                   ((req_data.ip_addr & subnet_mask_ff) == (local_ip_ff & subnet_mask_ff)));
   assign mcast = req_data.ip_addr[31:28] == MCAST_NIBBLE;
   assign off_subnet = (((req_data.ip_addr ^ local_ip_ff) & subnet_mask_ff) != '0) &&
                       (req_data.ip_addr[31:16] != LINK_LOCAL_PREFIX);
   assign bad_hdr = (req_data.hw_type != ARP_HW_ETHERNET) ||
                    (req_data.hw_len != ARP_HW_LEN) ||
                    (req_data.proto_len != ARP_PROTO_LEN) ||
                    (req_data.proto_type != ARP_PROTO_IPV4);

   always_comb begin
      cmd_data = '0;
      cmd_data.op = OP_DONE;
      cmd_data.status = ST_OK;
      cmd_data.action = ACT_NONE;
      case (req_data.kind)
         KIND_ARP: begin
            if (bad_hdr) begin
               cmd_data.status = ST_BAD_HDR;
            end else if (req_data.arp_opcode != ARP_OP_REQUEST) begin
               cmd_data.status = ST_UNK_OP;
            end else if ((local_ip_ff != '0) && (req_data.target_ip == local_ip_ff)) begin
               cmd_data.action = ACT_SEND_REPLY;
               cmd_data.mac = req_data.mac_addr;
               cmd_data.ip = req_data.ip_addr;
            end else begin
               cmd_data.status = ST_IGNORED;
            end
         end
         KIND_RESOLVE: begin
            if (bcast) begin
               cmd_data.action = ACT_SEND_IP;
               cmd_data.mac = '1;
            end else if (mcast) begin
               cmd_data.action = ACT_SEND_IP;
               cmd_data.mac = MCAST_PREFIX |
                              {25'd0, req_data.ip_addr[22:16] & MCAST_HIGH_BITS,
                               req_data.ip_addr[15:0]};
            end else if (off_subnet) begin
               if (gateway_ip_ff == '0) begin
                  cmd_data.status = ST_NO_ROUTE;
               end else begin
                  cmd_data.op = OP_RESOLVE;
                  cmd_data.ip = gateway_ip_ff;
               end
            end else begin
               cmd_data.op = OP_RESOLVE;
               cmd_data.ip = req_data.ip_addr;
            end
         end
         KIND_ADD: begin
            if (bcast || mcast) begin
               cmd_data.status = ST_NOT_UNICAST;
            end else begin
               cmd_data.op = OP_ADD;
               cmd_data.ip = req_data.ip_addr;
               cmd_data.mac = req_data.mac_addr;
            end
         end
         KIND_REMOVE: begin
            cmd_data.op = OP_REMOVE;
            cmd_data.ip = req_data.ip_addr;
         end
         default: ;
      endcase
   end

endmodule

// ----- rtl/sar_cmd_fifo.sv -----
module sar_cmd_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push_en,
   input  sar_pkg::cmd_type push_data,
   input  logic pop_en,
   output sar_pkg::cmd_type head,
   output logic empty,
   output logic full
);
   import sar_pkg::*;

   cmd_type mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff;
   logic [CMD_PTR_W-1:0] rd_ptr_ff;
   logic [CMD_PTR_W:0] count_ff;
   logic do_push;
   logic do_pop;

   assign empty = count_ff == '0;
   assign full = count_ff == (CMD_PTR_W+1)'(CMD_DEPTH);
   assign do_push = push_en && !full;
   assign do_pop = pop_en && !empty;
   assign head = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            mem_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff <= wr_ptr_ff + CMD_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + CMD_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (CMD_PTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (CMD_PTR_W+1)'(1);
         end
      end
   end

endmodule

// ----- rtl/sar_back.sv -----
module sar_back (
   input  logic clock,
   input  logic reset,
   input  sar_pkg::cmd_type cmd,
   input  logic cmd_empty,
   output logic cmd_pop,
   input  logic pop,
   output logic empty,
   output sar_pkg::rsp_type rsp_data
);
   import sar_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic [IDX_W-1:0] idx_ff;
   logic match_ff;
   logic [IDX_W-1:0] match_idx_ff;
   logic free_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic entry_valid_ff [TABLE_ENTRIES];
   logic [31:0] entry_ip_ff [TABLE_ENTRIES];
   logic [47:0] entry_mac_ff [TABLE_ENTRIES];
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic hit;
   logic vacant;
   logic last;
   logic slot_free;
   rsp_type fin_rsp;

   assign hit = entry_valid_ff[idx_ff] && (entry_ip_ff[idx_ff] == cmd.ip);
   assign vacant = !entry_valid_ff[idx_ff];
   assign last = idx_ff == IDX_W'(TABLE_ENTRIES - 1);
   assign slot_free = !rsp_valid_ff || pop;
   assign cmd_pop = ((state_ff == S_IDLE) && !cmd_empty && (cmd.op == OP_DONE) && slot_free) ||
                    ((state_ff == S_FINISH) && slot_free);
   assign empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      fin_rsp = '0;
      fin_rsp.status = ST_OK;
      fin_rsp.action = ACT_NONE;
      case (cmd.op)
         OP_RESOLVE: begin
            if (match_ff) begin
               fin_rsp.action = ACT_SEND_IP;
               fin_rsp.dest_mac = entry_mac_ff[match_idx_ff];
            end else begin
               fin_rsp.status = ST_NOT_FOUND;
            end
         end
         OP_ADD: begin
            if (!match_ff && !free_ff) fin_rsp.status = ST_FULL;
         end
         OP_REMOVE: begin
            if (!match_ff) fin_rsp.status = ST_NOT_FOUND;
         end
         default: begin
            fin_rsp.status = cmd.status;
            fin_rsp.action = cmd.action;
            fin_rsp.dest_mac = cmd.mac;
            fin_rsp.reply_ip = cmd.ip;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         match_ff <= 1'b0;
         free_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (cmd_pop) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff <= fin_rsp;
         end else if (pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!cmd_empty && (cmd.op != OP_DONE)) begin
                  state_ff <= S_SCAN;
                  idx_ff <= '0;
                  match_ff <= 1'b0;
                  free_ff <= 1'b0;
               end
            end
            S_SCAN: begin
               if (hit && !match_ff) begin
                  match_ff <= 1'b1;
                  match_idx_ff <= idx_ff;
               end
               if (vacant && !free_ff) begin
                  free_ff <= 1'b1;
                  free_idx_ff <= idx_ff;
               end
               if (last) begin
                  state_ff <= S_FINISH;
                  idx_ff <= '0;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            S_FINISH: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
                  if (cmd.op == OP_ADD) begin
                     if (match_ff) begin
                        entry_mac_ff[match_idx_ff] <= cmd.mac;
                     end else if (free_ff) begin
                        entry_valid_ff[free_idx_ff] <= 1'b1;
                        entry_ip_ff[free_idx_ff] <= cmd.ip;
                        entry_mac_ff[free_idx_ff] <= cmd.mac;
                     end
                  end else if ((cmd.op == OP_REMOVE) && match_ff) begin
                     entry_valid_ff[match_idx_ff] <= 1'b0;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // the command under work stays at the queue head
   a_cmd_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !cmd_empty)
      else $error("command queue drained during table scan");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SCAN) |-> (idx_ff == '0))
      else $error("scan index not parked outside scan");

   a_retire_result: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> rsp_valid_ff)
      else $error("retired command left no result");

   a_no_scan_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !cmd_pop)
      else $error("command retired in the middle of a scan");

endmodule

// ----- rtl/static_arp_resolver.sv -----
// table-free items (header checks, broadcast and multicast resolves) pass through the
// command queue and the result register; table items (resolve, add, remove) also pass
// the back end's scan and finish states. Table-free items go one per cycle while results
// are popped; table items go one at a time, held by the one-entry-per-cycle table scan
// a two-deep command queue lets the front accept while the back scans or a result waits
// reset: synchronous, clears the config registers, queues and the table valid bits
module static_arp_resolver (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  sar_pkg::req_type req_data,
   output logic empty,
   input  logic pop,
   output sar_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sar_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sar_pkg::CSR_DATA_W-1:0] csr_data
);
   import sar_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic front_push;
   logic cmd_full;
   logic cmd_empty;
   logic cmd_pop;

   assign full = cmd_full;

   sar_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (push),
      .req_data  (req_data),
      .cmd_full  (cmd_full),
      .cmd_push  (front_push),
      .cmd_data  (front_cmd)
   );

   sar_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (front_push),
      .push_data (front_cmd),
      .pop_en    (cmd_pop),
      .head      (head_cmd),
      .empty     (cmd_empty),
      .full      (cmd_full)
   );

   sar_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- test/static_arp_resolver_tb.sv -----
module static_arp_resolver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sar_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = TABLE_ENTRIES + 6;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int POOL_SIZE = 12;

   class arp_table_scoreboard;
      logic [31:0] local_ip;
      logic [31:0] subnet_mask;
      logic [31:0] gateway_ip;
      logic [47:0] local_mac;
      bit entry_valid [TABLE_ENTRIES];
      logic [31:0] entry_ip [TABLE_ENTRIES];
      logic [47:0] entry_mac [TABLE_ENTRIES];
      rsp_type expected_responses [$];
      int mismatches;

      function new();
         local_ip = '0;
         subnet_mask = '0;
         gateway_ip = '0;
         local_mac = '0;
         foreach (entry_valid[i]) begin
            entry_valid[i] = 1'b0;
            entry_ip[i] = '0;
            entry_mac[i] = '0;
         end
         mismatches = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [47:0] value);
         case (idx)
            CSR_LOCAL_IP: local_ip = value[31:0];
            CSR_SUBNET_MASK: subnet_mask = value[31:0];
            CSR_GATEWAY_IP: gateway_ip = value[31:0];
            CSR_LOCAL_MAC: local_mac = value;
            default: ;
         endcase
      endfunction

      function bit is_broadcast(logic [31:0] ip);
         logic [31:0] host;
         host = ~subnet_mask;
         if (ip == '1 || ip == '0) return 1'b1;
         return ((ip & host) == host) && ((ip & subnet_mask) == (local_ip & subnet_mask));
      endfunction

      function bit is_multicast(logic [31:0] ip);
         return ip[31:28] == MCAST_NIBBLE;
      endfunction

      function int find_entry(logic [31:0] ip);
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (entry_valid[i] && entry_ip[i] == ip) return i;
         return -1;
      endfunction

      function int free_slot();
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!entry_valid[i]) return i;
         return -1;
      endfunction

      function void record_request(req_type r);
         rsp_type e;
         logic [31:0] dst;
         int slot;
         e = '0;
         case (r.kind)
            KIND_ARP: begin
               if (r.hw_type != ARP_HW_ETHERNET || r.hw_len != ARP_HW_LEN ||
                   r.proto_len != ARP_PROTO_LEN || r.proto_type != ARP_PROTO_IPV4)
                  e.status = ST_BAD_HDR;
               else if (r.arp_opcode != ARP_OP_REQUEST)
                  e.status = ST_UNK_OP;
               else if (local_ip != '0 && r.target_ip == local_ip) begin
                  e.action = ACT_SEND_REPLY;
                  e.dest_mac = r.mac_addr;
                  e.reply_ip = r.ip_addr;
               end else
                  e.status = ST_IGNORED;
            end
            KIND_RESOLVE: begin
               dst = r.ip_addr;
               if (is_broadcast(dst)) begin
                  e.action = ACT_SEND_IP;
                  e.dest_mac = '1;
               end else if (is_multicast(dst)) begin
                  e.action = ACT_SEND_IP;
                  e.dest_mac = MCAST_PREFIX | 48'(dst & {9'b0, MCAST_HIGH_BITS, 16'hffff});
               end else begin
                  // off-link destinations go through the gateway
                  if (((dst ^ local_ip) & subnet_mask) != '0 &&
                      dst[31:16] != LINK_LOCAL_PREFIX) begin
                     if (gateway_ip == '0) e.status = ST_NO_ROUTE;
                     else dst = gateway_ip;
                  end
                  if (e.status == ST_OK) begin
                     slot = find_entry(dst);
                     if (slot < 0)
                        e.status = ST_NOT_FOUND;
                     else begin
                        e.action = ACT_SEND_IP;
                        e.dest_mac = entry_mac[slot];
                     end
                  end
               end
            end
            KIND_ADD: begin
               if (r.ip_addr == '0 || is_broadcast(r.ip_addr) || is_multicast(r.ip_addr))
                  e.status = ST_NOT_UNICAST;
               else begin
                  slot = find_entry(r.ip_addr);
                  if (slot < 0) slot = free_slot();
                  if (slot < 0)
                     e.status = ST_FULL;
                  else begin
                     entry_valid[slot] = 1'b1;
                     entry_ip[slot] = r.ip_addr;
                     entry_mac[slot] = r.mac_addr;
                  end
               end
            end
            default: begin
               slot = find_entry(r.ip_addr);
               if (slot < 0) e.status = ST_NOT_FOUND;
               else entry_valid[slot] = 1'b0;
            end
         endcase
         expected_responses.push_back(e);
      endfunction

      function void check_field(string name, logic [47:0] want, logic [47:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_responses.pop_front();
         check_field("status", 48'(want.status), 48'(got.status));
         check_field("action", 48'(want.action), 48'(got.action));
         check_field("dest_mac", want.dest_mac, got.dest_mac);
         check_field("reply_ip", 48'(want.reply_ip), 48'(got.reply_ip));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   req_type req_data = '0;
   logic empty;
   logic pop = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   arp_table_scoreboard sb = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   logic [31:0] ip_pool [POOL_SIZE];

   static_arp_resolver DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) sb.record_request(req_data);
         if (pop && !empty) sb.check_response(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [31:0] prefix_mask(int unsigned plen);
      return ~((32'd1 << (32 - plen)) - 32'd1);
   endfunction

   function automatic req_type make_request(kind_type k, logic [31:0] ip, logic [47:0] mac);
      req_type r;
      r.kind = k;
      r.hw_type = ARP_HW_ETHERNET;
      r.proto_type = ARP_PROTO_IPV4;
      r.hw_len = ARP_HW_LEN;
      r.proto_len = ARP_PROTO_LEN;
      r.arp_opcode = ARP_OP_REQUEST;
      r.ip_addr = ip;
      r.mac_addr = mac;
      r.target_ip = $urandom;
      return r;
   endfunction

   function automatic logic [31:0] pick_address();
      int unsigned slot;
      case ($urandom_range(9))
         0, 1, 2, 3: return ip_pool[$urandom_range(POOL_SIZE - 1)];
         4: begin
            slot = $urandom_range(TABLE_ENTRIES - 1);
            if (sb.entry_valid[slot]) return sb.entry_ip[slot];
            return ip_pool[$urandom_range(POOL_SIZE - 1)];
         end
         5: case ($urandom_range(2))
               0: return '1;
               1: return '0;
               default: return (sb.local_ip & sb.subnet_mask) | ~sb.subnet_mask;
            endcase
         6: return {MCAST_NIBBLE, 28'($urandom)};
         7: return {LINK_LOCAL_PREFIX, 16'($urandom)};
         8: return $urandom_range(1) ? sb.gateway_ip : sb.local_ip;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      int unsigned sel;
      sel = $urandom_range(99);
      r = make_request(KIND_ARP, pick_address(), rand48());
      if (sel < 35) begin
         r.ip_addr = $urandom_range(1) ? r.ip_addr : 32'($urandom);
         r.target_ip = $urandom_range(1) ? sb.local_ip : 32'($urandom);
         case ($urandom_range(9))
            0: r.hw_type = 16'($urandom);
            1: r.proto_type = 16'($urandom);
            2: r.hw_len = 8'($urandom);
            3: r.proto_len = 8'($urandom);
            4: begin
               r.hw_type = 16'($urandom);
               r.proto_type = 16'($urandom);
               r.hw_len = 8'($urandom);
               r.proto_len = 8'($urandom);
            end
            5, 6: r.arp_opcode = 16'($urandom);
            default: ;
         endcase
      end else begin
         if (sel < 65) r.kind = KIND_RESOLVE;
         else if (sel < 88) r.kind = KIND_ADD;
         else r.kind = KIND_REMOVE;
         r.hw_type = 16'($urandom);
         r.proto_type = 16'($urandom);
         r.hw_len = 8'($urandom);
         r.proto_len = 8'($urandom);
         r.arp_opcode = 16'($urandom);
      end
      return r;
   endfunction

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, value);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (sb.expected_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_phase(input int p);
      logic [31:0] lip;
      logic [31:0] msk;
      logic [31:0] gw;
      logic [47:0] mac;
      lip = $urandom;
      msk = prefix_mask($urandom_range(32));
      gw = $urandom;
      mac = rand48();
      case (p)
         0: begin
            lip = 32'hc0a8010a;
            msk = 32'hffffff00;
            gw = 32'hc0a80101;
            mac = 48'h020000000001;
         end
         1: begin
            lip = '1;
            msk = '0;
            gw = '0;
            mac = '1;
         end
         2: begin
            msk = '1;
            gw = '0;
            mac = '0;
         end
         3: begin
            msk = prefix_mask($urandom_range(1, 30));
            gw = (lip & msk) | (32'($urandom) & ~msk);
         end
         4: begin
            lip = '0;
            msk = 32'hffff0000;
            gw = '1;
         end
         default: ;
      endcase
      write_register(CSR_LOCAL_IP, 48'(lip));
      write_register(CSR_SUBNET_MASK, 48'(msk));
      write_register(CSR_GATEWAY_IP, 48'(gw));
      write_register(CSR_LOCAL_MAC, mac);
      csr_valid <= 1'b0;
      // half the pool on the local subnet, the rest but one anywhere, the last slot for the gateway
      for (int i = 0; i < POOL_SIZE - 1; i++)
         ip_pool[i] = (i < POOL_SIZE / 2) ? ((lip & msk) | (32'($urandom) & ~msk))
                                          : 32'($urandom);
      ip_pool[POOL_SIZE - 1] = gw;
   endtask

   task automatic run_directed();
      req_type r;
      logic [31:0] host;
      host = 32'hc0a80105;

      // unconfigured interface ignores a request for address zero
      r = make_request(KIND_ARP, host, rand48());
      r.target_ip = '0;
      send_request(r);
      drain();
      configure_phase(0);

      r = make_request(KIND_ARP, host, rand48());
      r.hw_type = 16'hffff;
      send_request(r);
      r = make_request(KIND_ARP, host, rand48());
      r.proto_type = '0;
      send_request(r);
      r = make_request(KIND_ARP, host, rand48());
      r.hw_len = 8'hff;
      send_request(r);
      r = make_request(KIND_ARP, host, rand48());
      r.proto_len = '0;
      send_request(r);
      r = make_request(KIND_ARP, host, rand48());
      r.arp_opcode = 16'h0002;
      send_request(r);
      r = make_request(KIND_ARP, host, rand48());
      r.arp_opcode = 16'hffff;
      r.target_ip = sb.local_ip;
      send_request(r);
      r = make_request(KIND_ARP, '1, '1);
      r.target_ip = sb.local_ip;
      send_request(r);
      r = make_request(KIND_ARP, '0, '0);
      r.target_ip = sb.local_ip ^ 32'h1;
      send_request(r);

      send_request(make_request(KIND_RESOLVE, '1, rand48()));
      send_request(make_request(KIND_RESOLVE, '0, rand48()));
      send_request(make_request(KIND_RESOLVE, 32'hc0a801ff, rand48()));
      send_request(make_request(KIND_RESOLVE, 32'hefffffff, rand48()));
      send_request(make_request(KIND_RESOLVE, 32'he0000000, rand48()));
      send_request(make_request(KIND_RESOLVE, host, rand48()));

      send_request(make_request(KIND_ADD, '0, rand48()));
      send_request(make_request(KIND_ADD, 32'he0000001, rand48()));
      send_request(make_request(KIND_ADD, 32'hc0a801ff, rand48()));
      send_request(make_request(KIND_ADD, sb.gateway_ip, 48'h00aabbccddee));
      send_request(make_request(KIND_RESOLVE, 32'h08080808, rand48()));
      send_request(make_request(KIND_RESOLVE, 32'ha9fe0102, rand48()));

      // overwrite of an existing entry, then removal twice
      send_request(make_request(KIND_ADD, host, '1));
      send_request(make_request(KIND_ADD, host, 48'h0a0b0c0d0e0f));
      send_request(make_request(KIND_RESOLVE, host, rand48()));
      send_request(make_request(KIND_REMOVE, host, rand48()));
      send_request(make_request(KIND_REMOVE, host, rand48()));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < PHASES; p++) begin
         drain();
         configure_phase(p);
         case (p % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 58; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 58; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         repeat (ITEMS_PER_PHASE) send_request(random_request());
      end
      drain();
      if (sb.mismatches == 0 && sb.expected_responses.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/sar_pkg.sv
rtl/sar_front.sv
rtl/sar_cmd_fifo.sv
rtl/sar_back.sv
rtl/static_arp_resolver.sv
test/static_arp_resolver_tb.sv
